FILE: sv/fdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the FDT structure-block token parser.
// No dependencies; used by every module of the block.
package fdt_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] TAG_BEGIN    = 32'h1;
    localparam logic [31:0] TAG_ENDNODE  = 32'h2;
    localparam logic [31:0] TAG_PROP     = 32'h3;
    localparam logic [31:0] TAG_NOP      = 32'h4;
    localparam logic [31:0] TAG_END      = 32'h9;
    localparam logic [7:0]  ALIGN_VERSION = 8'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_DT_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ODD  = 2'd1;

    localparam logic [7:0] DT_VERSION_RST = 8'd17;

    typedef enum logic [2:0] {
        M_TAG  = 3'd0,
        M_NAME = 3'd1,
        M_LEN  = 3'd2,
        M_OFF  = 3'd3,
        M_PAD  = 3'd4,
        M_DATA = 3'd5,
        M_STOP = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        EV_NODE_BEGIN = 3'd0,
        EV_NODE_NAME  = 3'd1,
        EV_NODE_END   = 3'd2,
        EV_NOP        = 3'd3,
        EV_PROP_HDR   = 3'd4,
        EV_PROP_DATA  = 3'd5,
        EV_END        = 3'd6,
        EV_ERROR      = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_STRING = 2'd1,
        CLS_CELLS  = 2'd2,
        CLS_BYTES  = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNK_TAG   = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } t_err;

    // running string-list check over property data bytes
    typedef struct packed {
        logic seg_has_char;
        logic string_ok;
        logic last_nul;
    } t_cls_flags;

    typedef struct packed {
        t_event      event_res;
        logic [6:0]  depth;
        logic [31:0] prop_len;
        logic [31:0] name_offset;
        logic [31:0] data_word;
        logic [2:0]  bytes_valid;
        logic        is_last;
        t_class      data_class;
        t_err        error_code;
    } t_result;

endpackage

FILE: sv/fdt_struct_token_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the FDT structure-block token parser: config registers,
// output register and handshake. Depends on fdt_pkg and fdt_parse_core.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------
//  in        | input     | i_in_valid / o_in_stall    | i_frame_start, i_word
//  out       | output    | o_out_valid / i_out_stall  | o_event_res .. o_error_code
//  cfg       | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word per cycle while o_in_stall is low; a result appears in the output register
// the cycle after its word is transferred. Latency is set by the single result register.
// Reset (i_rst_n low, synchronous) puts the parser in expect-tag at depth 0.
// o_in_stall rises only while a result is held and i_out_stall is high.
module fdt_struct_token_parser_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_frame_start,
    input  logic [31:0]                     i_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_event_res,
    output logic [6:0]                      o_depth,
    output logic [31:0]                     o_prop_len,
    output logic [31:0]                     o_name_offset,
    output logic [31:0]                     o_data_word,
    output logic [2:0]                      o_bytes_valid,
    output logic                            o_is_last,
    output logic [1:0]                      o_data_class,
    output logic [1:0]                      o_error_code,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    logic [7:0]                    r_dt_version;
    logic                          r_start_odd;
    logic                          r_out_valid;
    fdt_pkg::t_result              r_result;
    logic                          in_xfer;
    logic                          out_load;
    logic                          res_valid;
    fdt_pkg::t_result              res;
    logic [fdt_pkg::DEPTH_W-1:0]   core_depth;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_xfer     = i_in_valid & ~o_in_stall;
    assign out_load    = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt_version <= fdt_pkg::DT_VERSION_RST;
            r_start_odd  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fdt_pkg::CFG_DT_VERSION: r_dt_version <= i_cfg_data[7:0];
                fdt_pkg::CFG_START_ODD:  r_start_odd  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    fdt_parse_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_xfer),
        .i_frame_start (i_frame_start),
        .i_word        (i_word),
        .i_dt_version  (r_dt_version),
        .i_start_odd   (r_start_odd),
        .o_res_valid   (res_valid),
        .o_result      (res),
        .o_depth       (core_depth)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= in_xfer & res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && in_xfer) begin
            r_result <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_result.event_res;
    assign o_depth       = r_result.depth;
    assign o_prop_len    = r_result.prop_len;
    assign o_name_offset = r_result.name_offset;
    assign o_data_word   = r_result.data_word;
    assign o_bytes_valid = r_result.bytes_valid;
    assign o_is_last     = r_result.is_last;
    assign o_data_class  = r_result.data_class;
    assign o_error_code  = r_result.error_code;

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_depth <= fdt_pkg::DEPTH_W'(fdt_pkg::MAX_DEPTH))
        else $error("nesting depth above limit");

    a_error_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res == fdt_pkg::EV_ERROR |-> o_error_code != fdt_pkg::ERR_NONE)
        else $error("error event without error code");

    a_class_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_data_class != fdt_pkg::CLS_NONE
            |-> o_event_res == fdt_pkg::EV_PROP_DATA && o_is_last)
        else $error("data class outside last data word");

    a_no_result_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");
`endif

endmodule

FILE: sv/fdt_byte_class.sv
`timescale 1ns / 1ps
// Classifies up to four leading bytes of a property data word.
// Depends on fdt_pkg.
module fdt_byte_class (
    input  logic [31:0]         i_word,
    input  logic [2:0]          i_count,
    input  fdt_pkg::t_cls_flags i_flags,
    output fdt_pkg::t_cls_flags o_flags
);

    always_comb begin
        logic [7:0] b;
        o_flags = i_flags;
        for (int i = 0; i < 4; i++) begin
            b = i_word[31 - 8 * i -: 8];
            if (3'(i) < i_count) begin
                if (b == 8'h00) begin
                    // empty segment breaks a string list
                    if (!o_flags.seg_has_char) begin
                        o_flags.string_ok = 1'b0;
                    end
                    o_flags.seg_has_char = 1'b0;
                    o_flags.last_nul     = 1'b1;
                end else begin
                    if (b < 8'h20 || b > 8'h7E) begin
                        o_flags.string_ok = 1'b0;
                    end
                    o_flags.seg_has_char = 1'b1;
                    o_flags.last_nul     = 1'b0;
                end
            end
        end
    end

endmodule

FILE: sv/fdt_parse_core.sv
`timescale 1ns / 1ps
// Parser state and per-word token decode; one word per accepted transfer.
// Depends on fdt_pkg and fdt_byte_class.
module fdt_parse_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_frame_start,
    input  logic [31:0]                    i_word,
    input  logic [7:0]                     i_dt_version,
    input  logic                           i_start_odd,
    output logic                           o_res_valid,
    output fdt_pkg::t_result               o_result,
    output logic [fdt_pkg::DEPTH_W-1:0]    o_depth
);

    fdt_pkg::t_mode                r_mode, n_mode, mode_eff;
    logic [fdt_pkg::DEPTH_W-1:0]   r_depth, n_depth, depth_eff;
    logic [31:0]                   r_bytes_left, n_bytes_left, left_eff;
    logic [31:0]                   r_held_len, n_held_len, held_eff;
    logic                          r_parity, par_eff;
    fdt_pkg::t_cls_flags           r_flags, n_flags, cls_out;
    logic [2:0]                    data_cnt;
    logic [31:0]                   left_after;
    logic [2:0]                    name_cnt;
    logic                          name_last;

    // frame start clears the parser before the word is decoded
    assign mode_eff  = i_frame_start ? fdt_pkg::M_TAG : r_mode;
    assign depth_eff = i_frame_start ? '0 : r_depth;
    assign left_eff  = i_frame_start ? 32'd0 : r_bytes_left;
    assign held_eff  = i_frame_start ? 32'd0 : r_held_len;
    assign par_eff   = i_frame_start ? i_start_odd : r_parity;

    assign data_cnt   = (left_eff < 32'd4) ? left_eff[2:0] : 3'd4;
    assign left_after = left_eff - {29'd0, data_cnt};

    always_comb begin
        name_last = 1'b1;
        if (i_word[31:24] == 8'h00) begin
            name_cnt = 3'd0;
        end else if (i_word[23:16] == 8'h00) begin
            name_cnt = 3'd1;
        end else if (i_word[15:8] == 8'h00) begin
            name_cnt = 3'd2;
        end else if (i_word[7:0] == 8'h00) begin
            name_cnt = 3'd3;
        end else begin
            name_cnt  = 3'd4;
            name_last = 1'b0;
        end
    end

    fdt_byte_class u_byte_class (
        .i_word  (i_word),
        .i_count (data_cnt),
        .i_flags (r_flags),
        .o_flags (cls_out)
    );

    // next state
    always_comb begin
        n_mode       = mode_eff;
        n_depth      = depth_eff;
        n_bytes_left = left_eff;
        n_held_len   = held_eff;
        n_flags      = r_flags;
        case (mode_eff)
            fdt_pkg::M_TAG: begin
                if (i_word == fdt_pkg::TAG_BEGIN) begin
                    if (depth_eff >= fdt_pkg::DEPTH_W'(fdt_pkg::MAX_DEPTH)) begin
                        n_mode = fdt_pkg::M_STOP;
                    end else begin
                        n_depth = depth_eff + 1'b1;
                        n_mode  = fdt_pkg::M_NAME;
                    end
                end else if (i_word == fdt_pkg::TAG_ENDNODE) begin
                    if (depth_eff == '0) begin
                        n_mode = fdt_pkg::M_STOP;
                    end else begin
                        n_depth = depth_eff - 1'b1;
                    end
                end else if (i_word == fdt_pkg::TAG_NOP) begin
                    n_mode = fdt_pkg::M_TAG;
                end else if (i_word == fdt_pkg::TAG_PROP) begin
                    n_mode = fdt_pkg::M_LEN;
                end else begin
                    n_mode = fdt_pkg::M_STOP;
                end
            end
            fdt_pkg::M_NAME: begin
                if (name_last) begin
                    n_mode = fdt_pkg::M_TAG;
                end
            end
            fdt_pkg::M_LEN: begin
                n_held_len = i_word;
                n_mode     = fdt_pkg::M_OFF;
            end
            fdt_pkg::M_OFF: begin
                n_bytes_left = held_eff;
                n_flags      = '{seg_has_char: 1'b0, string_ok: 1'b1, last_nul: 1'b0};
                if (held_eff == 32'd0) begin
                    n_mode = fdt_pkg::M_TAG;
                end else if (i_dt_version < fdt_pkg::ALIGN_VERSION &&
                             held_eff >= 32'd8 && !par_eff) begin
                    n_mode = fdt_pkg::M_PAD;
                end else begin
                    n_mode = fdt_pkg::M_DATA;
                end
            end
            fdt_pkg::M_PAD: begin
                n_mode = fdt_pkg::M_DATA;
            end
            fdt_pkg::M_DATA: begin
                n_flags      = cls_out;
                n_bytes_left = left_after;
                if (left_after == 32'd0) begin
                    n_mode = fdt_pkg::M_TAG;
                end
            end
            fdt_pkg::M_STOP: begin
                n_mode = fdt_pkg::M_STOP;
            end
            default: begin
                n_mode = fdt_pkg::M_STOP;
            end
        endcase
    end

    // result decode
    always_comb begin
        o_res_valid = 1'b0;
        o_result    = '0;
        o_result.depth = 7'(depth_eff);
        case (mode_eff)
            fdt_pkg::M_TAG: begin
                o_res_valid = (i_word != fdt_pkg::TAG_PROP);
                if (i_word == fdt_pkg::TAG_BEGIN) begin
                    if (depth_eff >= fdt_pkg::DEPTH_W'(fdt_pkg::MAX_DEPTH)) begin
                        o_result.event_res  = fdt_pkg::EV_ERROR;
                        o_result.data_word  = i_word;
                        o_result.error_code = fdt_pkg::ERR_OVERFLOW;
                    end else begin
                        o_result.event_res = fdt_pkg::EV_NODE_BEGIN;
                    end
                end else if (i_word == fdt_pkg::TAG_ENDNODE) begin
                    if (depth_eff == '0) begin
                        o_result.event_res  = fdt_pkg::EV_ERROR;
                        o_result.data_word  = i_word;
                        o_result.error_code = fdt_pkg::ERR_UNDERFLOW;
                    end else begin
                        o_result.event_res = fdt_pkg::EV_NODE_END;
                    end
                end else if (i_word == fdt_pkg::TAG_NOP) begin
                    o_result.event_res = fdt_pkg::EV_NOP;
                end else if (i_word == fdt_pkg::TAG_END) begin
                    o_result.event_res = fdt_pkg::EV_END;
                end else begin
                    o_result.event_res  = fdt_pkg::EV_ERROR;
                    o_result.data_word  = i_word;
                    o_result.error_code = fdt_pkg::ERR_UNK_TAG;
                end
            end
            fdt_pkg::M_NAME: begin
                o_res_valid          = 1'b1;
                o_result.event_res   = fdt_pkg::EV_NODE_NAME;
                o_result.data_word   = i_word;
                o_result.bytes_valid = name_cnt;
                o_result.is_last     = name_last;
            end
            fdt_pkg::M_OFF: begin
                o_res_valid          = 1'b1;
                o_result.event_res   = fdt_pkg::EV_PROP_HDR;
                o_result.prop_len    = held_eff;
                o_result.name_offset = i_word;
            end
            fdt_pkg::M_DATA: begin
                o_res_valid          = 1'b1;
                o_result.event_res   = fdt_pkg::EV_PROP_DATA;
                o_result.data_word   = i_word;
                o_result.bytes_valid = data_cnt;
                if (left_after == 32'd0) begin
                    o_result.is_last = 1'b1;
                    if (cls_out.string_ok && cls_out.last_nul) begin
                        o_result.data_class = fdt_pkg::CLS_STRING;
                    end else if (held_eff[1:0] == 2'b00) begin
                        o_result.data_class = fdt_pkg::CLS_CELLS;
                    end else begin
                        o_result.data_class = fdt_pkg::CLS_BYTES;
                    end
                end
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= fdt_pkg::M_TAG;
            r_depth      <= '0;
            r_bytes_left <= '0;
            r_held_len   <= '0;
            r_parity     <= 1'b0;
            r_flags      <= '{seg_has_char: 1'b0, string_ok: 1'b1, last_nul: 1'b0};
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_depth      <= n_depth;
            r_bytes_left <= n_bytes_left;
            r_held_len   <= n_held_len;
            r_parity     <= ~par_eff;
            r_flags      <= n_flags;
        end
    end

    assign o_depth = r_depth;

endmodule

FILE: dv/fdt_token_checker.sv
`timescale 1ns / 1ps
// Token checker for fdt_struct_token_parser_unit: watches the word, token and
// register channels, predicts every token and compares it. Depends on fdt_pkg.
module fdt_token_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_frame_start,
    input  logic [31:0]                   i_word,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [2:0]                    i_event_res,
    input  logic [6:0]                    i_depth,
    input  logic [31:0]                   i_prop_len,
    input  logic [31:0]                   i_name_offset,
    input  logic [31:0]                   i_data_word,
    input  logic [2:0]                    i_bytes_valid,
    input  logic                          i_is_last,
    input  logic [1:0]                    i_data_class,
    input  logic [1:0]                    i_error_code,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [fdt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count
);

    localparam int REPORT_CAP = 40;

    // predictor state
    fdt_pkg::t_mode      mode;
    int unsigned         nest;
    logic [31:0]         left_bytes;
    logic [31:0]         len_held;
    logic                parity;
    fdt_pkg::t_cls_flags flags;
    logic [7:0]          ver_cfg;
    logic                odd_cfg;

    fdt_pkg::t_result token_q[$];
    fdt_pkg::t_result tok;
    fdt_pkg::t_result want;
    bit               emit;
    int               fails = 0;
    int               results = 0;

    task automatic scan_byte(input logic [7:0] b);
        if (b == 8'h00) begin
            if (!flags.seg_has_char)
                flags.string_ok = 1'b0;
            flags.seg_has_char = 1'b0;
            flags.last_nul     = 1'b1;
        end else begin
            if (b < 8'h20 || b > 8'h7E)
                flags.string_ok = 1'b0;
            flags.seg_has_char = 1'b1;
            flags.last_nul     = 1'b0;
        end
    endtask

    // advance the parser by one word; emit says whether a token comes out
    task automatic parse_word(input logic fs, input logic [31:0] w,
                              output bit emit_o, output fdt_pkg::t_result t);
        logic        p;
        logic [2:0]  cnt;
        logic        fin;
        logic [31:0] take;
        emit_o = 1'b0;
        t = '0;
        if (fs) begin
            mode       = fdt_pkg::M_TAG;
            nest       = 0;
            left_bytes = '0;
            len_held   = '0;
            parity     = odd_cfg;
        end
        p      = parity;
        parity = ~parity;
        t.depth = nest[6:0];
        case (mode)
            fdt_pkg::M_TAG: begin
                emit_o = 1'b1;
                if (w == fdt_pkg::TAG_BEGIN) begin
                    if (nest >= fdt_pkg::MAX_DEPTH) begin
                        t.event_res  = fdt_pkg::EV_ERROR;
                        t.data_word  = w;
                        t.error_code = fdt_pkg::ERR_OVERFLOW;
                        mode = fdt_pkg::M_STOP;
                    end else begin
                        t.event_res = fdt_pkg::EV_NODE_BEGIN;
                        nest++;
                        mode = fdt_pkg::M_NAME;
                    end
                end else if (w == fdt_pkg::TAG_ENDNODE) begin
                    if (nest == 0) begin
                        t.event_res  = fdt_pkg::EV_ERROR;
                        t.data_word  = w;
                        t.error_code = fdt_pkg::ERR_UNDERFLOW;
                        mode = fdt_pkg::M_STOP;
                    end else begin
                        t.event_res = fdt_pkg::EV_NODE_END;
                        nest--;
                    end
                end else if (w == fdt_pkg::TAG_NOP) begin
                    t.event_res = fdt_pkg::EV_NOP;
                end else if (w == fdt_pkg::TAG_PROP) begin
                    emit_o = 1'b0;
                    mode = fdt_pkg::M_LEN;
                end else if (w == fdt_pkg::TAG_END) begin
                    t.event_res = fdt_pkg::EV_END;
                    mode = fdt_pkg::M_STOP;
                end else begin
                    t.event_res  = fdt_pkg::EV_ERROR;
                    t.data_word  = w;
                    t.error_code = fdt_pkg::ERR_UNK_TAG;
                    mode = fdt_pkg::M_STOP;
                end
            end
            fdt_pkg::M_NAME: begin
                cnt = 3'd4;
                fin = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    if (!fin && w[31-8*i -: 8] == 8'h00) begin
                        cnt = i[2:0];
                        fin = 1'b1;
                    end
                end
                emit_o        = 1'b1;
                t.event_res   = fdt_pkg::EV_NODE_NAME;
                t.data_word   = w;
                t.bytes_valid = cnt;
                t.is_last     = fin;
                if (fin)
                    mode = fdt_pkg::M_TAG;
            end
            fdt_pkg::M_LEN: begin
                len_held = w;
                mode = fdt_pkg::M_OFF;
            end
            fdt_pkg::M_OFF: begin
                emit_o        = 1'b1;
                t.event_res   = fdt_pkg::EV_PROP_HDR;
                t.prop_len    = len_held;
                t.name_offset = w;
                left_bytes    = len_held;
                flags.seg_has_char = 1'b0;
                flags.string_ok    = 1'b1;
                flags.last_nul     = 1'b0;
                if (len_held == 0)
                    mode = fdt_pkg::M_TAG;
                else if (ver_cfg < fdt_pkg::ALIGN_VERSION && len_held >= 8 && !p)
                    mode = fdt_pkg::M_PAD;
                else
                    mode = fdt_pkg::M_DATA;
            end
            fdt_pkg::M_PAD: begin
                mode = fdt_pkg::M_DATA;
            end
            fdt_pkg::M_DATA: begin
                take = (left_bytes < 4) ? left_bytes : 32'd4;
                for (int i = 0; i < take; i++)
                    scan_byte(w[31-8*i -: 8]);
                left_bytes -= take;
                emit_o        = 1'b1;
                t.event_res   = fdt_pkg::EV_PROP_DATA;
                t.data_word   = w;
                t.bytes_valid = take[2:0];
                if (left_bytes == 0) begin
                    t.is_last = 1'b1;
                    if (flags.string_ok && flags.last_nul)
                        t.data_class = fdt_pkg::CLS_STRING;
                    else if (len_held[1:0] == 2'b00)
                        t.data_class = fdt_pkg::CLS_CELLS;
                    else
                        t.data_class = fdt_pkg::CLS_BYTES;
                    mode = fdt_pkg::M_TAG;
                end
            end
            fdt_pkg::M_STOP: begin
            end
            default: begin
                mode = fdt_pkg::M_STOP;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            if (fails < REPORT_CAP)
                $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode       = fdt_pkg::M_TAG;
            nest       = 0;
            left_bytes = '0;
            len_held   = '0;
            parity     = 1'b0;
            flags      = '{seg_has_char: 1'b0, string_ok: 1'b1, last_nul: 1'b0};
            ver_cfg    = fdt_pkg::DT_VERSION_RST;
            odd_cfg    = 1'b0;
            token_q.delete();
        end else begin
            // older token leaves before this edge's word is parsed
            if (i_out_valid && !i_out_stall) begin
                if (token_q.size() == 0) begin
                    if (fails < REPORT_CAP)
                        $error("token transfer with none expected: event %0d", i_event_res);
                    fails++;
                end else begin
                    want = token_q.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(i_event_res));
                    check_field("depth", 32'(want.depth), 32'(i_depth));
                    check_field("prop_len", want.prop_len, i_prop_len);
                    check_field("name_offset", want.name_offset, i_name_offset);
                    check_field("data_word", want.data_word, i_data_word);
                    check_field("bytes_valid", 32'(want.bytes_valid), 32'(i_bytes_valid));
                    check_field("is_last", 32'(want.is_last), 32'(i_is_last));
                    check_field("data_class", 32'(want.data_class), 32'(i_data_class));
                    check_field("error_code", 32'(want.error_code), 32'(i_error_code));
                    results++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_word(i_frame_start, i_word, emit, tok);
                if (emit)
                    token_q.push_back(tok);
            end
            // a register write applies from the next word on
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    fdt_pkg::CFG_DT_VERSION: ver_cfg = i_cfg_data[7:0];
                    fdt_pkg::CFG_START_ODD:  odd_cfg = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending      <= token_q.size();
        o_fail_count   <= fails;
        o_result_count <= results;
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for fdt_struct_token_parser_unit: builds structure blocks,
// drives words and register writes, and reports the verdict.
// Depends on fdt_pkg, the unit and fdt_token_checker.
module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_RESULTS = 100;
    localparam logic [fdt_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [fdt_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_frame_start;
    logic [31:0]                   i_word;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [2:0]                    o_event_res;
    logic [6:0]                    o_depth;
    logic [31:0]                   o_prop_len;
    logic [31:0]                   o_name_offset;
    logic [31:0]                   o_data_word;
    logic [2:0]                    o_bytes_valid;
    logic                          o_is_last;
    logic [1:0]                    o_data_class;
    logic [1:0]                    o_error_code;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [fdt_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                   i_cfg_data;

    int fail_count;
    int pending;
    int result_count;

    logic [32:0] word_q[$];   // {frame_start, word}
    logic [7:0]  byte_q[$];
    int          frame_base;
    bit          next_fs;
    logic [7:0]  cur_ver;
    bit          cur_odd;
    int          burst_left;
    int          words_sent;
    bit          hold_go;
    bit          hold_done;
    int          cycle_cnt = 0;

    fdt_struct_token_parser_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_frame_start (i_frame_start),
        .i_word        (i_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_res   (o_event_res),
        .o_depth       (o_depth),
        .o_prop_len    (o_prop_len),
        .o_name_offset (o_name_offset),
        .o_data_word   (o_data_word),
        .o_bytes_valid (o_bytes_valid),
        .o_is_last     (o_is_last),
        .o_data_class  (o_data_class),
        .o_error_code  (o_error_code),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    fdt_token_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_frame_start  (i_frame_start),
        .i_word         (i_word),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_event_res    (o_event_res),
        .i_depth        (o_depth),
        .i_prop_len     (o_prop_len),
        .i_name_offset  (o_name_offset),
        .i_data_word    (o_data_word),
        .i_bytes_valid  (o_bytes_valid),
        .i_is_last      (o_is_last),
        .i_data_class   (o_data_class),
        .i_error_code   (o_error_code),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("fdt_struct_token_parser_unit: mismatch");
        $finish;
    end

    // receiver: random stall segments plus one long hold-off on request
    initial begin
        int seg;
        int sel;
        hold_done = 1'b0;
        forever begin
            if (hold_go && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                sel = $urandom_range(0, 3);
                seg = $urandom_range(4, 60);
                repeat (seg) begin
                    case (sel)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                        2:       i_out_stall <= 1'($urandom_range(0, 1));
                        default: i_out_stall <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // ---------------- structure block generation ----------------

    task automatic push_word(input logic [31:0] w);
        word_q.push_back({next_fs, w});
        next_fs = 1'b0;
    endtask

    task automatic start_frame();
        frame_base = word_q.size();
        next_fs = 1'b1;
    endtask

    // big-endian packing; bytes past the end are filler
    task automatic pack_bytes();
        logic [31:0] w;
        logic [7:0]  b;
        for (int k = 0; k < byte_q.size(); k += 4) begin
            w = '0;
            for (int j = 0; j < 4; j++) begin
                b = (k + j < byte_q.size()) ? byte_q[k+j] : 8'($urandom_range(0, 255));
                w = {w[23:0], b};
            end
            push_word(w);
        end
    endtask

    function automatic logic [31:0] noise_word();
        case ($urandom_range(0, 7))
            0:       return fdt_pkg::TAG_BEGIN;
            1:       return fdt_pkg::TAG_ENDNODE;
            2:       return fdt_pkg::TAG_PROP;
            3:       return fdt_pkg::TAG_NOP;
            4:       return fdt_pkg::TAG_END;
            5:       return $urandom;
            6:       return $urandom_range(0, 15);
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic gen_name(input bit root);
        int n;
        byte_q.delete();
        if (root && $urandom_range(0, 1)) begin
            byte_q.push_back(8'h00);
        end else begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0)
                    byte_q.push_back(8'($urandom_range(1, 255)));
                else
                    byte_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            byte_q.push_back(8'h00);
        end
        pack_bytes();
    endtask

    task automatic gen_prop();
        int n;
        int slen;
        int off_idx;
        int bad;
        byte_q.delete();
        case ($urandom_range(0, 9))
            0: ;
            1, 2, 3: begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    slen = $urandom_range(1, 8);
                    repeat (slen) byte_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    byte_q.push_back(8'h00);
                end
                bad = $urandom_range(0, 7);
                if (bad == 0)
                    byte_q.push_front(8'h00);           // empty segment
                else if (bad == 1)
                    byte_q[0] = $urandom_range(0, 1) ? 8'($urandom_range(1, 31))
                                                     : 8'($urandom_range(127, 255));
                else if (bad == 2)
                    byte_q.delete(byte_q.size() - 1);   // unterminated
            end
            4, 5: begin
                n = $urandom_range(1, 6);
                repeat (4 * n) byte_q.push_back(8'($urandom_range(0, 255)));
            end
            6, 7: begin
                n = $urandom_range(1, 13);
                repeat (n) byte_q.push_back(8'($urandom_range(0, 255)));
            end
            8: begin
                n = $urandom_range(24, 64);
                repeat (n) byte_q.push_back(8'($urandom_range(0, 255)));
            end
            default: byte_q.push_back(8'h00);
        endcase
        push_word(fdt_pkg::TAG_PROP);
        push_word(32'(byte_q.size()));
        off_idx = word_q.size() - frame_base;
        push_word($urandom);
        // old blob versions pad data of 8 bytes or more to 8 bytes when the offset word is even
        if (cur_ver < fdt_pkg::ALIGN_VERSION && byte_q.size() >= 8 &&
            (cur_odd ^ (off_idx % 2)) == 0)
            push_word($urandom);
        pack_bytes();
    endtask

    task automatic gen_node(input int level);
        int n;
        push_word(fdt_pkg::TAG_BEGIN);
        gen_name(level == 0);
        n = $urandom_range(0, 3);
        repeat (n) begin
            if ($urandom_range(0, 5) == 0)
                push_word(fdt_pkg::TAG_NOP);
            gen_prop();
        end
        if (level < 2) begin
            n = $urandom_range(0, 2);
            repeat (n) gen_node(level + 1);
        end
        push_word(fdt_pkg::TAG_ENDNODE);
    endtask

    // a chain of nodes down to the depth limit
    task automatic gen_deep(input bit overflow);
        logic [7:0] c;
        for (int d = 0; d < fdt_pkg::MAX_DEPTH; d++) begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            push_word(fdt_pkg::TAG_BEGIN);
            push_word({c, 8'h00, 16'($urandom)});
        end
        if (overflow) begin
            push_word(fdt_pkg::TAG_BEGIN);
            push_word(noise_word());
        end else begin
            gen_prop();
            repeat (fdt_pkg::MAX_DEPTH) push_word(fdt_pkg::TAG_ENDNODE);
            push_word(fdt_pkg::TAG_END);
        end
    endtask

    task automatic gen_frame();
        int kind;
        int n;
        int cut;
        logic [31:0] w;
        kind = $urandom_range(0, 99);
        start_frame();
        if (kind >= 98) begin
            gen_deep($urandom_range(0, 1));
        end else if (kind >= 92) begin
            n = $urandom_range(1, 12);
            repeat (n) push_word(noise_word());
        end else if (kind >= 87) begin
            // length far beyond the frame: words stay data until next frame
            push_word(fdt_pkg::TAG_BEGIN);
            push_word(32'h6100_0000);
            push_word(fdt_pkg::TAG_PROP);
            push_word($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : ($urandom | 32'h100));
            push_word($urandom);
            n = $urandom_range(1, 6);
            repeat (n) push_word($urandom);
        end else begin
            if ($urandom_range(0, 5) == 0)
                push_word(fdt_pkg::TAG_NOP);
            gen_node(0);
            if (kind < 65) begin
                push_word(fdt_pkg::TAG_END);
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) push_word(noise_word());
            end else if (kind < 73) begin
                n = word_q.size() - frame_base;
                if (n > 1) begin
                    cut = $urandom_range(1, n - 1);
                    while (word_q.size() > frame_base + cut)
                        word_q.pop_back();
                end
            end else if (kind < 81) begin
                do begin
                    w = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom;
                end while (w == fdt_pkg::TAG_BEGIN || w == fdt_pkg::TAG_ENDNODE ||
                           w == fdt_pkg::TAG_PROP || w == fdt_pkg::TAG_NOP ||
                           w == fdt_pkg::TAG_END);
                push_word(w);
                repeat ($urandom_range(0, 3)) push_word(noise_word());
            end else begin
                push_word(fdt_pkg::TAG_ENDNODE);    // one close too many
                repeat ($urandom_range(0, 3)) push_word(noise_word());
            end
        end
    endtask

    // ---------------- channel drivers ----------------

    task automatic send_word(input logic fs, input logic [31:0] w);
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        i_in_valid    <= 1'b1;
        i_frame_start <= fs;
        i_word        <= w;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_queue();
        logic [32:0] item;
        while (word_q.size() > 0) begin
            item = word_q.pop_front();
            send_word(item[32], item[31:0]);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // caller lowers i_cfg_valid after the last write of a group
    task automatic write_reg(input logic [fdt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    initial begin
        int ph;
        int phase_base;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_frame_start <= 1'b0;
        i_word        <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        hold_go       <= 1'b0;
        cur_ver       = fdt_pkg::DT_VERSION_RST;
        cur_odd       = 1'b0;
        burst_left    = 0;
        words_sent    = 0;
        next_fs       = 1'b0;
        frame_base    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed block: empty root name, empty and short properties,
        // a 5-char name with its NUL in the next word, underflow, words
        // after a stop, unknown tag and END each opening a frame
        start_frame();
        push_word(fdt_pkg::TAG_BEGIN);
        push_word(32'h00AB_CDEF);
        push_word(fdt_pkg::TAG_PROP);
        push_word(32'h0000_0000);
        push_word(32'hFFFF_FFFF);
        push_word(fdt_pkg::TAG_NOP);
        push_word(fdt_pkg::TAG_PROP);
        push_word(32'd5);
        push_word(32'h0000_0000);
        push_word(32'h6162_0063);
        push_word(32'h00FF_FFFF);
        push_word(fdt_pkg::TAG_PROP);
        push_word(32'd3);
        push_word(32'h8000_0000);
        push_word(32'hFF01_7F00);
        push_word(fdt_pkg::TAG_BEGIN);
        push_word(32'h4142_4344);
        push_word(32'h4500_0000);
        push_word(fdt_pkg::TAG_ENDNODE);
        push_word(fdt_pkg::TAG_ENDNODE);
        push_word(fdt_pkg::TAG_ENDNODE);
        push_word(32'h1234_5678);
        start_frame();
        push_word(32'h0000_0007);
        start_frame();
        push_word(fdt_pkg::TAG_END);
        send_queue();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            if (ph > 0) begin
                case (ph)
                    1:       begin cur_ver = 8'd15;  cur_odd = 1'b0; end
                    2:       begin cur_ver = 8'd15;  cur_odd = 1'b1; end
                    3:       begin cur_ver = 8'd0;   cur_odd = 1'b1; end
                    4:       begin cur_ver = 8'd16;  cur_odd = 1'b0; end
                    5:       begin cur_ver = 8'd255; cur_odd = 1'b1; end
                    default: begin cur_ver = 8'd17;  cur_odd = 1'b0; end
                endcase
                write_reg(fdt_pkg::CFG_DT_VERSION, ($urandom & 32'hFFFF_FF00) | cur_ver);
                write_reg(fdt_pkg::CFG_START_ODD, ($urandom & 32'hFFFF_FFFE) | cur_odd);
                if (ph == 2) begin
                    write_reg(CFG_SPARE_A, $urandom);
                    write_reg(CFG_SPARE_B, $urandom);
                end
                i_cfg_valid <= 1'b0;
            end
            if (ph == 1) begin
                hold_go <= 1'b1;
                start_frame();
                gen_deep(1'b1);
                send_queue();
            end
            if (ph == 4) begin
                start_frame();
                gen_deep(1'b0);
                send_queue();
            end
            phase_base = result_count;
            while (result_count - phase_base < PHASE_RESULTS) begin
                gen_frame();
                send_queue();
            end
        end
        drain();

        $display("covered %0d words over %0d register settings (all versions, both parities)",
                 words_sent, NUM_PHASES);
        $display("checked %0d tokens incl. deep nesting, underflow, unknown tags and restarts",
                 result_count);
        if (fail_count == 0)
            $display("fdt_struct_token_parser_unit: match");
        else
            $display("fdt_struct_token_parser_unit: mismatch");
        $finish;
    end

endmodule
